/* rtl/tbm_pkg.sv */
// Shared types and constants for the token bucket meter with ECN marking.
// No dependencies; tbm_div, the top level and the testbench import this package.
`default_nettype none

package tbm_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BUCKET_SIZE  = 3'd0;
    localparam logic [2:0] CFG_RATE         = 3'd1;
    localparam logic [2:0] CFG_COLOR_AWARE  = 3'd2;
    localparam logic [2:0] CFG_ECN_ENABLE   = 3'd3;
    localparam logic [2:0] CFG_WINDOW_LIMIT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0] BUCKET_SIZE_RESET  = 32'd800000;
    localparam logic [31:0] RATE_RESET         = 32'd65536;
    localparam logic [15:0] WINDOW_LIMIT_RESET = 16'd1000;

    // Tokens granted when the timestamp runs backwards.
    localparam logic [64:0] BACKWARD_TOKENS = 65'd100000;
    // Physical overhead charged on top of every packet.
    localparam logic [17:0] PHY_OVERHEAD_BITS = 18'd64;

    // Window counters are 17 bits wide.
    localparam int unsigned WIN_W = 17;

    typedef struct packed {
        logic             start;
        logic [WIN_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } tbm_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tbm_div_sts_t;

endpackage

`default_nettype wire

/* rtl/tbm_mult.sv */
// Registered 32 x 32 unsigned multiplier shared by both refill products.
// Depends on nothing but its ports.
`default_nettype none

module tbm_mult (
    input  wire logic        aclk,
    input  wire logic [31:0] mul_a,
    input  wire logic [31:0] mul_b,
    output logic      [63:0] mul_prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {32'b0, mul_a} * {32'b0, mul_b};
    end

    assign mul_prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/tbm_div.sv */
// Restoring divider for the marking probability, one quotient bit a cycle.
// Depends on tbm_pkg for the request and status structs.
`default_nettype none

module tbm_div
    import tbm_pkg::*;
#(
    parameter int unsigned QW = 17
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire tbm_div_req_t div_req,
    output tbm_div_sts_t      div_sts,
    output logic [QW-1:0]     quotient
);

    localparam int unsigned CW = $clog2(QW + 1);

    logic [WIN_W:0]   rem_reg;
    logic [WIN_W-1:0] den_reg;
    logic [QW-1:0]    q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    logic [WIN_W:0] diff;
    logic [WIN_W:0] rem_sel;
    logic           ge;

    // The dividend never exceeds the divisor, so the quotient fits QW bits
    // and the first step already yields its top bit.
    assign ge      = rem_reg >= {1'b0, den_reg};
    assign diff    = rem_reg - {1'b0, den_reg};
    assign rem_sel = ge ? diff : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                cnt_reg <= CW'(QW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            rem_reg <= {1'b0, div_req.dividend};
            den_reg <= div_req.divisor;
            q_reg   <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= {rem_sel[WIN_W-1:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign div_sts.busy = (cnt_reg != '0);
    assign div_sts.done = done_reg;
    assign quotient     = q_reg;

endmodule

`default_nettype wire

/* rtl/token_bucket_meter_ecn.sv */
// Top level of the single-rate token bucket meter with random ECN marking.
// Depends on tbm_pkg, tbm_mult and tbm_div.
//
//  Channel  Ports                          Moves
//  s_       s_tvalid s_tready s_tdata/user one packet descriptor per item
//  m_       m_tvalid m_tready m_tdata/user one verdict per item
//  cfg_     cfg_we cfg_addr cfg_wdata      register write, no back-pressure
//
// From acceptance to a valid result an item goes through one operand load, two passes
// through the shared multiplier, a refill step, a charge step and the load of the
// output register, which waits while a result is still held there unread.
// An item that closes the window also waits in S_DIV for the serial divider.
// s_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous and active low; it restores all but the per-item registers.
`default_nettype none

module token_bucket_meter_ecn
    import tbm_pkg::*;
#(
    parameter int unsigned PROB_FRACTION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Fields from bit 0: arrival_time[47:0], packet_bits[64:48],
    // random_fraction[80:65], zero fill [87:81].
    input  wire logic [87:0] s_tdata,
    // Fields from bit 0: incoming_color[1:0], forced_red[2].
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: passed[0], zero fill [7:1].
    output logic      [7:0]  m_tdata,
    // Fields from bit 0: ecn_mark[0].
    output logic      [0:0]  m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    localparam int unsigned PW    = PROB_FRACTION_BITS + 1;
    localparam int unsigned CMP_W = PROB_FRACTION_BITS + 17;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_MUL_LO = 3'd2;
    localparam logic [2:0] S_MUL_HI = 3'd3;
    localparam logic [2:0] S_BUCKET = 3'd4;
    localparam logic [2:0] S_CHARGE = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;

    // Configuration.
    logic [31:0] size_reg;
    logic [31:0] rate_reg;
    logic        color_aware_reg;
    logic        ecn_enable_reg;
    logic [15:0] limit_reg;

    // Meter state.
    logic [31:0]      fill_reg;
    logic [47:0]      last_time_reg;
    logic [PW-1:0]    prob_reg;
    logic [WIN_W-1:0] packets_reg;
    logic [WIN_W-1:0] drops_reg;

    // Per-item working registers.
    logic [47:0] elapsed_reg;
    logic        backward_reg;
    logic [16:0] pkt_bits_reg;
    logic [1:0]  color_reg;
    logic        forced_reg;
    logic [15:0] rnd_reg;
    logic [31:0] lo_part_reg;
    logic [64:0] tokens_reg;
    logic        pass_reg;
    logic        mark_reg;

    logic        m_tvalid_reg;
    logic        m_passed_reg;
    logic        m_mark_reg;

    logic        s_accept;
    logic [47:0] in_time;
    logic [31:0] mul_a;
    logic [63:0] mul_prod;
    logic [31:0] headroom;
    logic        refill_fits;
    logic [17:0] cost;
    logic        green_in;
    logic        pass_now;
    logic        mark_now;
    logic [WIN_W-1:0] drops_upd;
    logic        window_end;
    logic        out_free;

    tbm_div_req_t  div_req;
    tbm_div_sts_t  div_sts;
    logic [PW-1:0] div_q;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_time  = s_tdata[47:0];
    assign out_free = !m_tvalid_reg || m_tready;

    // The multiplier takes the low 16 elapsed bits first, then the high 32.
    assign mul_a = (state_reg == S_LOAD) ? {16'b0, elapsed_reg[15:0]} : elapsed_reg[47:16];

    tbm_mult u_mult (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (rate_reg),
        .mul_prod (mul_prod)
    );

    assign headroom    = size_reg - fill_reg;
    assign refill_fits = (fill_reg <= size_reg) && (tokens_reg <= {33'b0, headroom});

    assign cost      = {1'b0, pkt_bits_reg} + PHY_OVERHEAD_BITS;
    assign green_in  = (!color_aware_reg || (color_reg == 2'd0)) && !forced_reg;
    assign pass_now  = green_in && (fill_reg >= {14'b0, cost});
    assign mark_now  = pass_now && ecn_enable_reg &&
                       ({1'b0, rnd_reg, {PROB_FRACTION_BITS{1'b0}}} <
                        CMP_W'({prob_reg, 16'b0}));
    assign drops_upd = pass_now ? drops_reg : drops_reg + 1'b1;
    assign window_end = packets_reg > {1'b0, limit_reg};

    assign div_req.start    = (state_reg == S_CHARGE) && window_end;
    assign div_req.dividend = drops_upd;
    assign div_req.divisor  = packets_reg;

    tbm_div #(
        .QW (PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_req  (div_req),
        .div_sts  (div_sts),
        .quotient (div_q)
    );

    // Sequencer, meter state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            size_reg        <= BUCKET_SIZE_RESET;
            rate_reg        <= RATE_RESET;
            color_aware_reg <= 1'b0;
            ecn_enable_reg  <= 1'b0;
            limit_reg       <= WINDOW_LIMIT_RESET;
            fill_reg        <= BUCKET_SIZE_RESET;
            last_time_reg   <= '0;
            prob_reg        <= '0;
            packets_reg     <= '0;
            drops_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_BUCKET_SIZE: begin
                        size_reg <= cfg_wdata;
                        fill_reg <= cfg_wdata;
                    end
                    CFG_RATE:         rate_reg        <= cfg_wdata;
                    CFG_COLOR_AWARE:  color_aware_reg <= cfg_wdata[0];
                    CFG_ECN_ENABLE:   ecn_enable_reg  <= cfg_wdata[0];
                    CFG_WINDOW_LIMIT: limit_reg       <= cfg_wdata[15:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        last_time_reg <= in_time;
                        packets_reg   <= packets_reg + 1'b1;
                        state_reg     <= S_LOAD;
                    end
                end
                S_LOAD:   state_reg <= S_MUL_LO;
                S_MUL_LO: state_reg <= S_MUL_HI;
                S_MUL_HI: state_reg <= S_BUCKET;
                S_BUCKET: begin
                    fill_reg  <= refill_fits ? fill_reg + tokens_reg[31:0] : size_reg;
                    state_reg <= S_CHARGE;
                end
                S_CHARGE: begin
                    if (pass_now) begin
                        fill_reg <= fill_reg - {14'b0, cost};
                    end
                    drops_reg <= drops_upd;
                    state_reg <= window_end ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (div_sts.done) begin
                        prob_reg    <= div_q;
                        packets_reg <= '0;
                        drops_reg   <= '0;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Item payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            elapsed_reg  <= in_time - last_time_reg;
            backward_reg <= in_time < last_time_reg;
            pkt_bits_reg <= s_tdata[64:48];
            rnd_reg      <= s_tdata[80:65];
            color_reg    <= s_tuser[1:0];
            forced_reg   <= s_tuser[2];
        end
        if (state_reg == S_MUL_LO) begin
            lo_part_reg <= mul_prod[47:16];
        end
        if (state_reg == S_MUL_HI) begin
            tokens_reg <= backward_reg ? BACKWARD_TOKENS
                                       : {1'b0, mul_prod} + {33'b0, lo_part_reg};
        end
        if (state_reg == S_CHARGE) begin
            pass_reg <= pass_now;
            mark_reg <= mark_now;
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_passed_reg <= pass_reg;
            m_mark_reg   <= mark_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_passed_reg};
    assign m_tuser  = m_mark_reg;

endmodule

`default_nettype wire

/* rtl/tbm_checker.sv */
// Port-level checker for the token bucket meter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module tbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // A dropped packet is never marked.
    a_mark_needs_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || !m_tuser[0]))
        else $error("ECN mark on a dropped item");

    // One item at a time: the input closes right after an item is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after accepting an item");

    // A result must not rise early: m_tvalid is checked at one sample point after an item is taken.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ##1 !$rose(m_tvalid))
        else $error("result shown too early");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("block not idle after reset");

endmodule

bind token_bucket_meter_ecn tbm_checker u_tbm_checker (.*);

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for token_bucket_meter_ecn: stream driver, stream monitor
// and a cycle-free model of the meter that predicts each verdict.
// Depends on tbm_pkg and the token_bucket_meter_ecn RTL.
module tb;
    import tbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PROB_BITS    = 16;
    localparam int unsigned PHASE_ITEMS  = 250;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned STALL_CYCLES = 2000;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [47:0] arrival_time;
        logic [16:0] packet_bits;
        logic [1:0]  color;
        logic        forced_red;
        logic [15:0] rnd;
    } pkt_t;

    typedef struct {
        logic passed;
        logic ecn_mark;
    } verdict_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [87:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;

    token_bucket_meter_ecn #(
        .PROB_FRACTION_BITS(PROB_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Model copy of the registers and the meter state.
    logic [31:0]        cfg_size;
    logic [31:0]        cfg_rate;
    logic               cfg_aware;
    logic               cfg_ecn;
    logic [15:0]        cfg_limit;
    logic [31:0]        bucket_fill;
    logic [47:0]        last_arrival;
    logic [PROB_BITS:0] mark_prob;
    logic [16:0]        win_packets;
    logic [16:0]        win_drops;

    pkt_t     pkt_queue[$];
    verdict_t verdict_queue[$];
    pkt_t     send_pkt;
    int       send_gap;
    int       recv_wait;
    int       stall_left;
    int       stall_requests = 0;
    int       stall_seen;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    bit       send_no_idle = 1'b0;
    bit       recv_no_idle = 1'b0;
    logic [47:0] gen_time = '0;

    // Refill, charge and window update for one packet; returns its verdict.
    function automatic verdict_t meter_packet(pkt_t p);
        logic [64:0] elapsed;
        logic [64:0] tokens;
        logic [17:0] cost;
        logic [63:0] num;
        logic        green_in;
        verdict_t    v;
        win_packets = win_packets + 17'd1;
        if (p.arrival_time < last_arrival) begin
            tokens = BACKWARD_TOKENS;
        end else begin
            elapsed = 65'(p.arrival_time - last_arrival);
            tokens = (elapsed >> 16) * cfg_rate + (((elapsed & 65'hFFFF) * cfg_rate) >> 16);
        end
        last_arrival = p.arrival_time;
        if (bucket_fill <= cfg_size && tokens <= 65'(cfg_size - bucket_fill))
            bucket_fill = bucket_fill + tokens[31:0];
        else
            bucket_fill = cfg_size;
        cost = 18'(p.packet_bits) + PHY_OVERHEAD_BITS;
        green_in = (!cfg_aware || p.color == 2'd0) && !p.forced_red;
        v.passed = green_in && (bucket_fill >= 32'(cost));
        v.ecn_mark = 1'b0;
        if (v.passed) begin
            bucket_fill = bucket_fill - 32'(cost);
            // Exact comparison of rnd / 2^16 against mark_prob / 2^PROB_BITS.
            v.ecn_mark = cfg_ecn &&
                ((64'(p.rnd) << PROB_BITS) < (64'(mark_prob) << 16));
        end else begin
            win_drops = win_drops + 17'd1;
        end
        if (32'(win_packets) > 32'(cfg_limit)) begin
            num = 64'(win_drops) << PROB_BITS;
            mark_prob = (PROB_BITS + 1)'(num / 64'(win_packets));
            win_packets = '0;
            win_drops = '0;
        end
        return v;
    endfunction

    function automatic pkt_t make_pkt(logic [47:0] t, logic [16:0] bits, logic [1:0] color,
                                      logic forced, logic [15:0] rnd);
        pkt_t p;
        p.arrival_time = t;
        p.packet_bits = bits;
        p.color = color;
        p.forced_red = forced;
        p.rnd = rnd;
        return p;
    endfunction

    // Mostly small forward steps in time, with backward steps and wild jumps mixed in.
    function automatic pkt_t random_pkt();
        pkt_t p;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 3)
            gen_time = 48'({$urandom, $urandom});
        else if (r < 8)
            gen_time = gen_time - 48'($urandom_range(1, 5000));
        else
            gen_time = gen_time + 48'($urandom_range(0, 3000));
        p.arrival_time = gen_time;
        p.packet_bits = ($urandom_range(0, 9) < 7) ? 17'($urandom_range(0, 4000)) : 17'($urandom);
        p.color = ($urandom_range(0, 9) < 8) ? 2'd0 : 2'($urandom_range(1, 3));
        p.forced_red = ($urandom_range(0, 99) < 8);
        p.rnd = 16'($urandom);
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic apply_settings(input logic [31:0] size, input logic [31:0] rate,
                                  input logic aware, input logic ecn,
                                  input logic [15:0] limit);
        logic [2:0]  idx [5];
        logic [31:0] vals [5];
        idx = '{CFG_BUCKET_SIZE, CFG_RATE, CFG_COLOR_AWARE, CFG_ECN_ENABLE, CFG_WINDOW_LIMIT};
        vals = '{size, rate, 32'(aware), 32'(ecn), 32'(limit)};
        for (int i = 0; i < 5; i++) begin
            @(posedge aclk);
            cfg_we <= 1'b1;
            cfg_addr <= idx[i];
            cfg_wdata <= vals[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_size = size;
        bucket_fill = size;
        cfg_rate = rate;
        cfg_aware = aware;
        cfg_ecn = ecn;
        cfg_limit = limit;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pkt_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Input driver: holds an item until it is taken, then waits its drawn gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_queue.push_back(meter_packet(send_pkt));
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pkt_queue.size() != 0) begin
                    send_pkt = pkt_queue.pop_front();
                    s_tdata <= {7'b0, send_pkt.rnd, send_pkt.packet_bits, send_pkt.arrival_time};
                    s_tuser <= {send_pkt.forced_red, send_pkt.color};
                    s_tvalid <= 1'b1;
                    send_gap = send_no_idle ? 0 : $urandom_range(0, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started whenever the sequence asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
            stall_seen <= 0;
        end else if (stall_seen != stall_requests) begin
            stall_left <= STALL_CYCLES;
            stall_seen <= stall_requests;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Result monitor: checks each verdict against the oldest prediction.
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch("result item with no prediction waiting");
                end else begin
                    want = verdict_queue.pop_front();
                    if (m_tdata[0] !== want.passed)
                        report_mismatch($sformatf("passed got %b want %b",
                                                  m_tdata[0], want.passed));
                    if (m_tuser[0] !== want.ecn_mark)
                        report_mismatch($sformatf("ecn_mark got %b want %b",
                                                  m_tuser[0], want.ecn_mark));
                end
                recv_wait = recv_no_idle ? 0 : $urandom_range(0, 6);
            end else if (recv_wait != 0) begin
                recv_wait--;
            end
            m_tready <= (recv_wait == 0) && (stall_left == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        cfg_size = BUCKET_SIZE_RESET;
        cfg_rate = RATE_RESET;
        cfg_aware = 1'b0;
        cfg_ecn = 1'b0;
        cfg_limit = WINDOW_LIMIT_RESET;
        bucket_fill = BUCKET_SIZE_RESET;
        last_arrival = '0;
        mark_prob = '0;
        win_packets = '0;
        win_drops = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: a short window so that drops quickly produce a marking probability.
        apply_settings(BUCKET_SIZE_RESET, RATE_RESET, 1'b1, 1'b1, 16'd3);
        @(negedge aclk);
        pkt_queue.push_back(make_pkt(48'd0, 17'd0, 2'd0, 1'b0, 16'd0));
        pkt_queue.push_back(make_pkt(48'd10, 17'h1FFFF, 2'd0, 1'b0, 16'hFFFF));
        pkt_queue.push_back(make_pkt(48'd20, 17'd100, 2'd0, 1'b1, 16'd0));
        pkt_queue.push_back(make_pkt(48'd30, 17'd100, 2'd1, 1'b0, 16'd0));
        pkt_queue.push_back(make_pkt(48'd40, 17'd100, 2'd2, 1'b0, 16'd0));
        pkt_queue.push_back(make_pkt(48'd50, 17'd100, 2'd3, 1'b0, 16'd0));
        pkt_queue.push_back(make_pkt(48'd60, 17'd100, 2'd0, 1'b0, 16'd0));
        pkt_queue.push_back(make_pkt(48'd70, 17'd100, 2'd0, 1'b0, 16'hFFFF));
        pkt_queue.push_back(make_pkt(48'd80, 17'd100, 2'd0, 1'b0, 16'h7FFF));
        // Time running backwards, then the largest possible forward step, then back again.
        pkt_queue.push_back(make_pkt(48'd5, 17'd0, 2'd0, 1'b0, 16'd0));
        pkt_queue.push_back(make_pkt(48'hFFFF_FFFF_FFFF, 17'd0, 2'd0, 1'b0, 16'd0));
        pkt_queue.push_back(make_pkt(48'd0, 17'd0, 2'd0, 1'b0, 16'd0));
        // Back-to-back maximum packets empty the bucket.
        for (int i = 0; i < 8; i++)
            pkt_queue.push_back(make_pkt(48'd1, 17'h1FFFF, 2'd0, 1'b0, 16'($urandom)));
        pkt_queue.push_back(make_pkt(48'd1, 17'd0, 2'd3, 1'b1, 16'd0));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            send_no_idle = (ph == 1) || (ph == 6);
            recv_no_idle = (ph == 1);
            case (ph)
                0: apply_settings(32'd800000, 32'd65536, 1'b0, 1'b1, 16'd20);
                1: apply_settings(32'd300000, 32'd6553, 1'b1, 1'b1, 16'd10);
                2: apply_settings(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0);
                3: apply_settings(32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1, 16'd1);
                4: apply_settings(32'd200000, 32'd1000, 1'b1, 1'b1, 16'hFFFF);
                7: apply_settings(32'd500000, 32'd40000, 1'b1, 1'b0, 16'd5);
                default: apply_settings(32'($urandom_range(100000, 2000000)), $urandom,
                                        1'($urandom), 1'b1, 16'($urandom_range(1, 50)));
            endcase
            @(negedge aclk);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pkt_queue.push_back(random_pkt());
            // Hold the result side off while the sender keeps offering items.
            if (ph == 4)
                stall_requests++;
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* token_bucket_meter_ecn.f */
rtl/tbm_pkg.sv
rtl/tbm_mult.sv
rtl/tbm_div.sv
rtl/token_bucket_meter_ecn.sv
rtl/tbm_checker.sv
sim/tb.sv
